/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the two-axis step pulse block.
// Needs clk_i and rst_ni in the scope of each use; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// A consequence that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* sv/tasph_pkg.sv */
// Types and constants of the two-axis step pulse generator with homing.
// Used by tasph_cfg, tasph_axis and the top level; depends on nothing.
package tasph_pkg;

  localparam int DistWidth   = 15;
  localparam int PeriodWidth = 16;

  // Reset values of the configuration registers and of the compare value.
  localparam logic [DistWidth-1:0]   HomeDistanceRst    = 15'd32000;
  localparam logic [PeriodWidth-1:0] HomePeriodRst      = 16'd600;
  localparam logic [DistWidth-1:0]   BackoffDistanceRst = 15'd4000;
  localparam logic [PeriodWidth-1:0] BackoffPeriodRst   = 16'd400;
  localparam logic [PeriodWidth-1:0] CompareRst         = 16'd400;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_MOVE = 2'd1,
    ACT_HOME = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    PH_NONE     = 2'd0,
    PH_APPROACH = 2'd1,
    PH_BACKOFF  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    REG_HOME_DISTANCE    = 2'd0,
    REG_HOME_PERIOD      = 2'd1,
    REG_BACKOFF_DISTANCE = 2'd2,
    REG_BACKOFF_PERIOD   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [DistWidth-1:0]   home_distance;
    logic [PeriodWidth-1:0] home_period;
    logic [DistWidth-1:0]   backoff_distance;
    logic [PeriodWidth-1:0] backoff_period;
  } cfg_t;

  // Command for one axis, decoded from one accepted beat.
  typedef struct packed {
    logic                   tick;
    logic                   move;
    logic                   home;
    logic                   limit;
    logic                   dir;
    logic [DistWidth-1:0]   distance;
    logic [PeriodWidth-1:0] period;
  } axis_cmd_t;

  typedef struct packed {
    logic   step;
    logic   dir;
    logic   busy;
    phase_e phase;
  } axis_stat_t;

endpackage

/* sv/tasph_cfg.sv */
// Configuration registers of the two-axis step pulse generator.
// Depends on tasph_pkg.
module tasph_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_i,
  input  logic [1:0]                index_i,
  input  logic [15:0]               data_i,
  output tasph_pkg::cfg_t           cfg_o
);
  import tasph_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the register index of a write.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      unique case (reg_idx_e'(index_i))
        REG_HOME_DISTANCE:    cfg_d.home_distance    = data_i[DistWidth-1:0];
        REG_HOME_PERIOD:      cfg_d.home_period      = data_i;
        REG_BACKOFF_DISTANCE: cfg_d.backoff_distance = data_i[DistWidth-1:0];
        REG_BACKOFF_PERIOD:   cfg_d.backoff_period   = data_i;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.home_distance    <= HomeDistanceRst;
      cfg_q.home_period      <= HomePeriodRst;
      cfg_q.backoff_distance <= BackoffDistanceRst;
      cfg_q.backoff_period   <= BackoffPeriodRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/tasph_axis.sv */
// One stepper axis: tick counter, step toggling, step count and homing phase.
// Depends on tasph_pkg; the top level instantiates it once per axis.
module tasph_axis #(
  parameter int COUNT_WIDTH = 15
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  tasph_pkg::axis_cmd_t   cmd_i,
  input  tasph_pkg::cfg_t        cfg_i,
  output tasph_pkg::axis_stat_t  stat_o
);
  import tasph_pkg::*;

  logic                   busy_q, busy_d;
  logic                   dir_q, dir_d;
  logic                   step_q, step_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0] tgt_q, tgt_d;
  logic [PeriodWidth-1:0] cmp_q, cmp_d;
  logic [PeriodWidth-1:0] tc_q, tc_d;
  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   match;

  assign match   = (tc_q == cmp_q);
  assign cnt_inc = cnt_q + COUNT_WIDTH'(1);

  // Next state for one beat: a tick, a move, or the start of homing.
  always_comb begin
    busy_d  = busy_q;
    dir_d   = dir_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    tgt_d   = tgt_q;
    cmp_d   = cmp_q;
    tc_d    = tc_q;
    phase_d = phase_q;
    if (cmd_i.home) begin
      phase_d = PH_APPROACH;
      dir_d   = 1'b1;
      tgt_d   = COUNT_WIDTH'(cfg_i.home_distance);
      cmp_d   = cfg_i.home_period;
      busy_d  = 1'b1;
      tc_d    = '0;
    end else if (cmd_i.move) begin
      dir_d  = cmd_i.dir;
      tgt_d  = COUNT_WIDTH'(cmd_i.distance);
      cmp_d  = cmd_i.period;
      busy_d = 1'b1;
      tc_d   = '0;
    end else if (cmd_i.tick) begin
      if (!match) begin
        tc_d = tc_q + PeriodWidth'(1);
      end else begin
        tc_d = '0;
        if (busy_q) begin
          if (!step_q) begin
            step_d = 1'b1;
          end else begin
            // Falling edge of the step pin: one step done.
            step_d = 1'b0;
            cnt_d  = cnt_inc;
            if (cnt_inc >= tgt_q) begin
              phase_d = PH_NONE;
              cnt_d   = '0;
              busy_d  = 1'b0;
            end
            // The limit switch stops the axis except while backing off; in the approach it starts the back-off.
            if (cmd_i.limit && phase_d != PH_BACKOFF) begin
              busy_d = 1'b0;
              cnt_d  = '0;
              if (phase_d == PH_APPROACH) begin
                phase_d = PH_BACKOFF;
                dir_d   = 1'b0;
                tgt_d   = COUNT_WIDTH'(cfg_i.backoff_distance);
                cmp_d   = cfg_i.backoff_period;
                busy_d  = 1'b1;
                tc_d    = '0;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      dir_q   <= 1'b0;
      step_q  <= 1'b0;
      cnt_q   <= '0;
      tgt_q   <= '0;
      cmp_q   <= CompareRst;
      tc_q    <= '0;
      phase_q <= PH_NONE;
    end else if (en_i) begin
      busy_q  <= busy_d;
      dir_q   <= dir_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
      tgt_q   <= tgt_d;
      cmp_q   <= cmp_d;
      tc_q    <= tc_d;
      phase_q <= phase_d;
    end
  end

  assign stat_o.step  = step_q;
  assign stat_o.dir   = dir_q;
  assign stat_o.busy  = busy_q;
  assign stat_o.phase = phase_q;

endmodule

/* sv/two_axis_step_pulse_homing.sv */
// Two-axis step/direction pulse generator with homing. The block takes one beat in
// every clock cycle; s_axis_tready only drops while a result waits on a low
// m_axis_tready. Each beat is a timer tick, a move command for one axis, or a
// homing command for both axes, and it gives one result beat with both axes' step,
// direction, busy and homing phase after that beat. The axis state registers are
// updated at acceptance by a single pass of compare and count logic and form the
// result register, valid in the next cycle. Configuration writes are always ready.
// Depends on tasph_pkg, tasph_cfg, tasph_axis and assert_macros.svh.
`include "assert_macros.svh"
module two_axis_step_pulse_homing #(
  parameter int COUNT_WIDTH = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // axis[0], direction[1], distance[16:2], period[32:17], x_limit[33], y_limit[34]
  input  logic [39:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // x_step[0], x_dir[1], x_busy[2], x_phase[4:3],
  // y_step[5], y_dir[6], y_busy[7], y_phase[9:8]
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import tasph_pkg::*;

  logic       accept;
  logic       out_valid_q, out_valid_d;
  cfg_t       cfg;
  axis_cmd_t  cmd_x, cmd_y;
  axis_stat_t stat_x, stat_y;
  action_e    action;
  logic       is_tick, is_move, is_home;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  tasph_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  // Decode the action of the beat; the unused code leaves the state alone.
  assign action = action_e'(s_axis_tuser);
  always_comb begin
    is_tick = 1'b0;
    is_move = 1'b0;
    is_home = 1'b0;
    unique case (action)
      ACT_TICK: is_tick = 1'b1;
      ACT_MOVE: is_move = 1'b1;
      ACT_HOME: is_home = 1'b1;
      default:  is_tick = 1'b0;
    endcase
  end

  // Per-axis commands.
  always_comb begin
    cmd_x.tick     = is_tick;
    cmd_x.move     = is_move && !s_axis_tdata[0];
    cmd_x.home     = is_home;
    cmd_x.limit    = s_axis_tdata[33];
    cmd_x.dir      = s_axis_tdata[1];
    cmd_x.distance = s_axis_tdata[16:2];
    cmd_x.period   = s_axis_tdata[32:17];
    cmd_y          = cmd_x;
    cmd_y.move     = is_move && s_axis_tdata[0];
    cmd_y.limit    = s_axis_tdata[34];
  end

  tasph_axis #(.COUNT_WIDTH(COUNT_WIDTH)) u_axis_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .cmd_i  (cmd_x),
    .cfg_i  (cfg),
    .stat_o (stat_x)
  );

  tasph_axis #(.COUNT_WIDTH(COUNT_WIDTH)) u_axis_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .cmd_i  (cmd_y),
    .cfg_i  (cfg),
    .stat_o (stat_y)
  );

  // A result beat is pending from each accepted beat until it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0,
                          stat_y.phase, stat_y.busy, stat_y.dir, stat_y.step,
                          stat_x.phase, stat_x.busy, stat_x.dir, stat_x.step};

  // Checks.
  `ASSERT_ALWAYS(a_x_phase_busy, (stat_x.phase == PH_NONE) || stat_x.busy, "x homing while idle")
  `ASSERT_ALWAYS(a_y_phase_busy, (stat_y.phase == PH_NONE) || stat_y.busy, "y homing while idle")
  `ASSERT_NEXT(a_accept_valid, accept, m_axis_tvalid, "accepted beat gave no result")
  `ASSERT_ALWAYS(a_stall_back, !(m_axis_tvalid && !m_axis_tready) || !s_axis_tready,
                 "input taken while result stalled")

endmodule
